// File: rtl/core/ttld_pkg.sv
// ttld_pkg: shared widths, register codes and lamp decode for the transient
// trigger lamp driver. No dependencies.
`default_nettype none

package ttld_pkg;

    localparam int SAMPLE_W = 8;
    localparam int LONG_W   = 28;
    localparam int SHORT_W  = 20;
    localparam int OFFSET_W = 20;
    localparam int PHASE_W  = 4;
    localparam int LAMP_W   = 3;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(1024);

    // Register indexes (byte address = 4 * index)
    localparam logic [0:0] REG_TRIGGER_OFFSET = 1'b0;

    localparam logic [PHASE_W-1:0] PHASE_MODULUS    = PHASE_W'(15);
    localparam logic [PHASE_W-1:0] PHASE_FIRST_END  = PHASE_W'(5);
    localparam logic [PHASE_W-1:0] PHASE_SECOND_END = PHASE_W'(10);

    localparam logic [LAMP_W-1:0] LAMPS_ALL_OFF = 3'b111;
    localparam logic [LAMP_W-1:0] LAMP_FIRST    = 3'b110;
    localparam logic [LAMP_W-1:0] LAMP_SECOND   = 3'b101;
    localparam logic [LAMP_W-1:0] LAMP_THIRD    = 3'b011;

    typedef struct packed {
        logic [LAMP_W-1:0] lamp_drive;
        logic              triggered;
    } t_result;

    // Active-low lamp pattern for a phase, five phases per lamp
    function automatic logic [LAMP_W-1:0] lamp_for_phase(input logic [PHASE_W-1:0] phase);
        logic [LAMP_W-1:0] lamps;
        if (phase < PHASE_FIRST_END) begin
            lamps = LAMP_FIRST;
        end else if (phase < PHASE_SECOND_END) begin
            lamps = LAMP_SECOND;
        end else begin
            lamps = LAMP_THIRD;
        end
        return lamps;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ttld_update.sv
// ttld_update: next-state logic for both leaky integrators, the trigger
// compare and the lamp phase sequencer. Depends on ttld_pkg.
`default_nettype none

module ttld_update #(
    parameter int LONG_DECAY_SHIFT  = 20,
    parameter int SHORT_DECAY_SHIFT = 12,
    parameter int ALIGN_SHIFT       = 8
) (
    input  wire logic [ttld_pkg::LONG_W-1:0]   i_long_sum,
    input  wire logic [ttld_pkg::SHORT_W-1:0]  i_short_sum,
    input  wire logic [ttld_pkg::PHASE_W-1:0]  i_phase,
    input  wire logic [ttld_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [ttld_pkg::OFFSET_W-1:0] i_offset,
    output logic      [ttld_pkg::LONG_W-1:0]   o_long_sum,
    output logic      [ttld_pkg::SHORT_W-1:0]  o_short_sum,
    output logic      [ttld_pkg::PHASE_W-1:0]  o_phase,
    output ttld_pkg::t_result                  o_result
);

    localparam int SCALED_W = ttld_pkg::LONG_W - ALIGN_SHIFT;
    localparam int MAX_W    = (SCALED_W > ttld_pkg::OFFSET_W) ? SCALED_W : ttld_pkg::OFFSET_W;
    localparam int CMP_W    = ((MAX_W > ttld_pkg::SHORT_W) ? MAX_W : ttld_pkg::SHORT_W) + 1;

    logic [SCALED_W-1:0]          scaled_long;
    logic [CMP_W-1:0]             threshold;
    logic                         fire;
    logic [ttld_pkg::PHASE_W:0]   phase_inc;
    logic [ttld_pkg::PHASE_W-1:0] phase_next;

    always_comb begin
        o_long_sum  = i_long_sum - (i_long_sum >> LONG_DECAY_SHIFT)
                      + ttld_pkg::LONG_W'(i_sample);
        o_short_sum = i_short_sum - (i_short_sum >> SHORT_DECAY_SHIFT)
                      + ttld_pkg::SHORT_W'(i_sample);

        // Compare at full precision so the threshold sum never wraps
        scaled_long = o_long_sum[ttld_pkg::LONG_W-1:ALIGN_SHIFT];
        threshold   = CMP_W'(scaled_long) + CMP_W'(i_offset);
        fire        = CMP_W'(o_short_sum) > threshold;

        // Wrap mod 15; also covers an out-of-range phase of 15
        phase_inc = {1'b0, i_phase} + (ttld_pkg::PHASE_W+1)'(1);
        if (phase_inc >= {1'b0, ttld_pkg::PHASE_MODULUS}) begin
            phase_next = ttld_pkg::PHASE_W'(phase_inc - {1'b0, ttld_pkg::PHASE_MODULUS});
        end else begin
            phase_next = phase_inc[ttld_pkg::PHASE_W-1:0];
        end

        if (fire) begin
            o_phase             = i_phase;
            o_result.lamp_drive = ttld_pkg::LAMPS_ALL_OFF;
        end else begin
            o_phase             = phase_next;
            o_result.lamp_drive = ttld_pkg::lamp_for_phase(phase_next);
        end
        o_result.triggered = fire;
    end

endmodule

`default_nettype wire

// File: rtl/core/transient_trigger_led_driver.sv
// transient_trigger_led_driver: top level with sample input register, state
// registers, result register and the APB register. Depends on ttld_pkg, ttld_update.
//
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+-------------------------------
//  sample in | i_in_valid   | o_in_stall   | i_sample
//  result    | o_out_valid  | i_out_stall  | o_lamp_drive, o_triggered
//  config    | psel/penable | pready (= 1) | paddr, pwdata, pwrite, prdata
//
// One transaction per cycle sustained while i_out_stall is low; o_out_valid rises once
// the sample has passed the input register, then the result register. The integrator update,
// compare and phase step are combinational between those registers.
// Synchronous reset clears sums, phase and valids; trigger_offset resets to 1024.
// A stalled result holds; the input register keeps taking samples until it too is full.
`default_nettype none

module transient_trigger_led_driver #(
    parameter int LONG_DECAY_SHIFT  = 20,
    parameter int SHORT_DECAY_SHIFT = 12,
    parameter int ALIGN_SHIFT       = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [ttld_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [ttld_pkg::LAMP_W-1:0]       o_lamp_drive,
    output logic                                   o_triggered,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ttld_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ttld_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [ttld_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    logic                              r_in_valid;
    logic [ttld_pkg::SAMPLE_W-1:0]     r_sample;
    logic [ttld_pkg::LONG_W-1:0]       r_long_sum;
    logic [ttld_pkg::SHORT_W-1:0]      r_short_sum;
    logic [ttld_pkg::PHASE_W-1:0]      r_phase;
    logic [ttld_pkg::OFFSET_W-1:0]     r_offset;
    logic                              r_out_valid;
    ttld_pkg::t_result                 r_result;

    logic [ttld_pkg::LONG_W-1:0]       n_long_sum;
    logic [ttld_pkg::SHORT_W-1:0]      n_short_sum;
    logic [ttld_pkg::PHASE_W-1:0]      n_phase;
    ttld_pkg::t_result                 n_result;

    logic in_accept;
    logic advance;
    logic cfg_write;
    logic reg_sel;

    ttld_update #(
        .LONG_DECAY_SHIFT  (LONG_DECAY_SHIFT),
        .SHORT_DECAY_SHIFT (SHORT_DECAY_SHIFT),
        .ALIGN_SHIFT       (ALIGN_SHIFT)
    ) u_update (
        .i_long_sum  (r_long_sum),
        .i_short_sum (r_short_sum),
        .i_phase     (r_phase),
        .i_sample    (r_sample),
        .i_offset    (r_offset),
        .o_long_sum  (n_long_sum),
        .o_short_sum (n_short_sum),
        .o_phase     (n_phase),
        .o_result    (n_result)
    );

    // Stage 2 moves when the input register holds a sample and the result register is empty or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign reg_sel   = paddr[ttld_pkg::APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready
                       && (reg_sel == ttld_pkg::REG_TRIGGER_OFFSET);

    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            ttld_pkg::REG_TRIGGER_OFFSET: prdata = ttld_pkg::APB_DATA_W'(r_offset);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_long_sum  <= '0;
            r_short_sum <= '0;
            r_phase     <= '0;
            r_offset    <= ttld_pkg::OFFSET_RESET;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_long_sum  <= n_long_sum;
                r_short_sum <= n_short_sum;
                r_phase     <= n_phase;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_write) begin
                r_offset <= pwdata[ttld_pkg::OFFSET_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sample;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_lamp_drive = r_result.lamp_drive;
    assign o_triggered  = r_result.triggered;

endmodule

`default_nettype wire

// File: rtl/core/ttld_checker.sv
// ttld_checker: port-level assertions for transient_trigger_led_driver and
// the bind that attaches them. Depends on ttld_pkg.
`default_nettype none

module ttld_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [ttld_pkg::LAMP_W-1:0]   o_lamp_drive,
    input wire logic                          o_triggered,
    input wire logic                          pready
);

    // A fired result always blanks every lamp
    a_fire_blanks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_triggered) |-> (o_lamp_drive == ttld_pkg::LAMPS_ALL_OFF))
        else $error("triggered result with a lamp lit");

    // Otherwise exactly one lamp is lit
    a_one_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_triggered) |->
            ((o_lamp_drive == ttld_pkg::LAMP_FIRST) ||
             (o_lamp_drive == ttld_pkg::LAMP_SECOND) ||
             (o_lamp_drive == ttld_pkg::LAMP_THIRD)))
        else $error("untriggered result without exactly one lamp lit");

    // No result straight out of reset: two register stages stand in between
    a_no_early_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid in the cycle after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_lamp_drive) && $stable(o_triggered)))
        else $error("stalled result transaction changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("config port inserted a wait state");

endmodule

bind transient_trigger_led_driver ttld_checker u_ttld_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_lamp_drive (o_lamp_drive),
    .o_triggered  (o_triggered),
    .pready       (pready)
);

`default_nettype wire
